// ===== src/isort_pkg.sv =====
// Shared types for the insertion sorter: the link that each cell in the
// chain hands to its neighbors, and the per-cycle chain control.
// No dependencies.
package isort_pkg;

    localparam int unsigned DATA_W = 32;

    typedef logic signed [DATA_W-1:0] t_data;

    // What one cell shows to its neighbors.
    typedef struct packed {
        logic  valid;   // cell holds an element
        logic  ge;      // cell is at or past the insertion point
        t_data value;
    } t_link;

    // Control broadcast to every cell.
    typedef struct packed {
        logic ins;      // insert i_value this cycle
        logic shift;    // move every element one cell toward the output
    } t_ctrl;

endpackage

// ===== src/isort_cell.sv =====
// One cell of the insertion chain: holds a single element and its valid bit.
// Depends on isort_pkg.
module isort_cell
    import isort_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_ctrl i_ctrl,
    input  t_data i_value,
    input  t_link i_left,
    input  t_link i_right,
    output t_link o_link
);

    logic  r_valid;
    t_data r_value;
    logic  n_valid;
    t_data n_value;
    logic  w_ge;

    // Strictly greater keeps equal elements ahead of the new one (stable).
    assign w_ge = !r_valid || (r_value > i_value);

    always_comb begin
        n_valid = r_valid;
        n_value = r_value;
        if (i_ctrl.ins && w_ge) begin
            if (!i_left.ge) begin
                n_valid = 1'b1;
                n_value = i_value;
            end else begin
                n_valid = i_left.valid;
                n_value = i_left.value;
            end
        end else if (i_ctrl.shift) begin
            n_valid = i_right.valid;
            n_value = i_right.value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    assign o_link = '{valid: r_valid, ge: w_ge, value: r_value};

endmodule

// ===== src/insertion_sorter_core.sv =====
// Stable insertion sorter: a chain of MAX_ITEMS cells, one element each.
// Depends on isort_pkg and isort_cell.
//
// Usage: stream signed 32-bit values in, one transfer per cycle; o_ready stays
// high while a set is loading. Every value is compared against all held cells
// at once and lands in place in the same cycle, ahead of any larger value and
// behind any equal one. The transfer that carries i_last starts emission:
// o_ready drops and the set comes out of cell 0 in ascending order, one result
// per cycle while i_ready is high, since every output transfer shifts the
// whole chain by one cell. The next set may start the cycle after the result
// with o_last_res is transferred. Values arriving while all cells are full
// are dropped (a final value too; the held set is still emitted) and
// o_overflow is high on every result of that set. No clearing pass is needed
// after reset.
module insertion_sorter_core
    import isort_pkg::*;
#(
    parameter int unsigned MAX_ITEMS = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input channel
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [31:0] i_value,
    input  logic        i_last,
    // output channel
    output logic        o_valid,
    input  logic        i_ready,
    output logic [31:0] o_value_res,
    output logic        o_last_res,
    output logic        o_overflow
);

    t_link w_link [MAX_ITEMS];
    t_ctrl w_ctrl;
    logic  w_in_xfer;
    logic  w_out_xfer;
    logic  w_full;

    logic  r_draining;   // emitting the held set
    logic  r_dropped;    // an element of this set was dropped

    assign w_in_xfer  = i_valid && o_ready;
    assign w_out_xfer = o_valid && i_ready;
    assign w_full     = w_link[MAX_ITEMS-1].valid;

    // A full chain takes no insert; the value is simply lost.
    assign w_ctrl.ins   = w_in_xfer && !w_full;
    assign w_ctrl.shift = w_out_xfer;

    genvar g;
    generate
        for (g = 0; g < MAX_ITEMS; g++) begin : g_cell
            t_link w_left;
            t_link w_right;

            if (g == 0) begin : g_head
                // Nothing is ahead of cell 0: it takes the new value when it
                // is at the insertion point.
                assign w_left = '{valid: 1'b1, ge: 1'b0, value: '0};
            end else begin : g_mid
                assign w_left = w_link[g-1];
            end

            if (g == MAX_ITEMS - 1) begin : g_tail
                assign w_right = '{valid: 1'b0, ge: 1'b1, value: '0};
            end else begin : g_body
                assign w_right = w_link[g+1];
            end

            isort_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_ctrl  (w_ctrl),
                .i_value (t_data'(i_value)),
                .i_left  (w_left),
                .i_right (w_right),
                .o_link  (w_link[g])
            );
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_draining <= 1'b0;
            r_dropped  <= 1'b0;
        end else begin
            if (w_in_xfer && w_full) begin
                r_dropped <= 1'b1;
            end
            // the final value may itself be dropped; the chain is never
            // empty at that point, so emission always has work
            if (w_in_xfer && i_last) begin
                r_draining <= 1'b1;
            end
            if (w_out_xfer && o_last_res) begin
                r_draining <= 1'b0;
                r_dropped  <= 1'b0;
            end
        end
    end

    assign o_ready     = !r_draining;
    assign o_valid     = r_draining && w_link[0].valid;
    assign o_value_res = w_link[0].value;
    // cell 0 holds the last result once nothing stands behind it
    assign o_last_res  = !w_link[1].valid;
    assign o_overflow  = r_dropped;

endmodule

// ===== src/isort_checker.sv =====
// Port-level checks for insertion_sorter_core, attached by bind.
// Depends on insertion_sorter_core, the target of its bind.
module isort_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_ready,
    input logic        i_last,
    input logic        o_valid,
    input logic        i_ready,
    input logic [31:0] o_value_res,
    input logic        o_last_res,
    input logic        o_overflow
);

    // no input taken while a set is being emitted
    a_no_load_while_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !o_ready)
        else $error("input ready during emission");

    // a final input transfer starts emission: a result is valid once the drain flag is set
    a_last_starts_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready && i_last) |=> o_valid)
        else $error("no result after final input");

    // the final result ends the set and reopens the input
    a_last_res_ends_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_ready && o_last_res) |=> (!o_valid && o_ready))
        else $error("emission continued past final result");

    // overflow is the same on every result of a set
    a_overflow_steady: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_ready && !o_last_res) |=>
            (o_valid && (o_overflow == $past(o_overflow))))
        else $error("overflow changed within a set");

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_value_res)))
        else $error("stalled result changed");

endmodule

bind insertion_sorter_core isort_checker u_isort_checker (.*);

// ===== tb/sv/tb_insertion_sorter_core.sv =====
`timescale 1ns / 100ps
// Self-checking bench for insertion_sorter_core: feeds sets of signed values and checks
// each sorted result against a queue-based sorter kept in step with the input transfers.
// Depends on isort_pkg and the insertion_sorter_core RTL.
module tb_insertion_sorter_core;
    import isort_pkg::*;

    localparam int unsigned SORT_DEPTH    = 64;
    localparam int unsigned RAND_ITEMS    = 260;
    localparam int unsigned CYCLE_LIMIT   = 400000;
    localparam int unsigned MAX_ERR_LINES = 40;

    typedef struct packed {
        t_data      value;
        logic       last;
        logic       drain;     // hold off until every pending result has come out
        logic [1:0] phase;     // idle profile in force while this item goes in
    } t_in_item;

    typedef struct packed {
        t_data value;
        logic  last;
        logic  ovf;
    } t_sorted_res;

    logic        i_clk   = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [31:0] i_value = '0;
    logic        i_last  = 1'b0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [31:0] o_value_res;
    logic        o_last_res;
    logic        o_overflow;

    t_in_item    pending[$];
    t_data       held_vals[$];     // sorted set being built
    logic        set_dropped = 1'b0;
    t_sorted_res sorted_due[$];    // results still owed by the block

    int unsigned sent_count  = 0;
    int unsigned taken_count = 0;
    int unsigned item_total  = 0;
    int unsigned err_count   = 0;
    int unsigned cycle_count = 0;
    logic [1:0]  cur_phase   = 2'd0;
    bit          run_live    = 1'b0;

    insertion_sorter_core #(
        .MAX_ITEMS(SORT_DEPTH)
    ) u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_value    (i_value),
        .i_last     (i_last),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_value_res(o_value_res),
        .o_last_res (o_last_res),
        .o_overflow (o_overflow)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    task automatic report_mismatch(input string msg);
        err_count++;
        if (err_count <= MAX_ERR_LINES) begin
            $display("MISMATCH @%0t: %s", $realtime, msg);
        end
    endtask

    // Stable insert: the new value lands behind every held value <= it.
    // A full store drops the value; a last transfer flushes the whole set.
    task automatic sort_in(input t_data v, input logic is_last);
        int unsigned pos;
        t_sorted_res r;
        if (held_vals.size() >= SORT_DEPTH) begin
            set_dropped = 1'b1;
        end else begin
            pos = held_vals.size();
            while (pos > 0 && held_vals[pos-1] > v) pos--;
            held_vals.insert(pos, v);
        end
        if (is_last) begin
            foreach (held_vals[k]) begin
                r.value = held_vals[k];
                r.last  = (k == held_vals.size() - 1);
                r.ovf   = set_dropped;
                sorted_due.push_back(r);
            end
            held_vals.delete();
            set_dropped = 1'b0;
        end
    endtask

    function automatic int unsigned tx_idle_pct(input logic [1:0] ph);
        case (ph)
            2'd0:    return 31;
            2'd1:    return 62;
            default: return 0;
        endcase
    endfunction

    function automatic int unsigned rx_idle_pct(input logic [1:0] ph);
        case (ph)
            2'd0:    return 62;
            2'd1:    return 31;
            default: return 0;
        endcase
    endfunction

    // Full-range, narrow-band (duplicates), extreme and sign-plus-low-byte values.
    function automatic t_data pick_value();
        logic [31:0] raw;
        raw = $urandom;
        case ($urandom_range(0, 9))
            5, 6:    return t_data'($signed($urandom_range(0, 8)) - 4);
            7:       return 32'sh7fff_ffff;
            8:       return 32'sh8000_0000;
            9:       return t_data'(raw & 32'h8000_00ff);
            default: return t_data'(raw);
        endcase
    endfunction

    task automatic add_item(input t_data v, input logic is_last, input logic drain);
        t_in_item it;
        it.value = v;
        it.last  = is_last;
        it.drain = drain;
        it.phase = (item_total < 100) ? 2'd0 : (item_total < 200) ? 2'd1 : 2'd2;
        pending.push_back(it);
        item_total++;
    endtask

    // Driver: presents the next pending item once the current one has transferred.
    always @(negedge i_clk) begin : driver
        t_in_item nxt;
        bit       may_send;
        if (run_live) begin
            if (!(i_valid && taken_count < sent_count)) begin
                may_send = (pending.size() != 0);
                if (may_send) begin
                    if (pending[0].drain && sorted_due.size() != 0) may_send = 1'b0;
                    else if ($urandom_range(0, 99) < tx_idle_pct(pending[0].phase))
                        may_send = 1'b0;
                end
                if (may_send) begin
                    nxt = pending.pop_front();
                    i_valid   <= 1'b1;
                    i_value   <= nxt.value;
                    i_last    <= nxt.last;
                    cur_phase  = nxt.phase;
                    sent_count++;
                end else begin
                    i_valid <= 1'b0;
                end
            end
            i_ready <= ($urandom_range(0, 99) >= rx_idle_pct(cur_phase));
        end
    end

    // Monitor: input transfers feed the sorter, output transfers are checked.
    always @(posedge i_clk) begin : monitor
        t_sorted_res want;
        if (i_rst_n) begin
            if (i_valid && o_ready) begin
                sort_in(t_data'(i_value), i_last);
                taken_count++;
            end
            if (o_valid && i_ready) begin
                if (sorted_due.size() == 0) begin
                    report_mismatch($sformatf("result %0d with none pending",
                                              $signed(o_value_res)));
                end else begin
                    want = sorted_due.pop_front();
                    if (o_value_res !== want.value)
                        report_mismatch($sformatf("value %0d, want %0d",
                                                  $signed(o_value_res), want.value));
                    if (o_last_res !== want.last)
                        report_mismatch($sformatf("last_res %b, want %b (value %0d)",
                                                  o_last_res, want.last, want.value));
                    if (o_overflow !== want.ovf)
                        report_mismatch($sformatf("overflow %b, want %b (value %0d)",
                                                  o_overflow, want.ovf, want.value));
                end
            end
        end
    end

    always @(posedge i_clk) begin : watchdog
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("insertion_sorter_core regression: fail");
            $finish;
        end
    end

    initial begin : stimulus
        int unsigned set_idx;
        int unsigned set_len;
        // single-element sets at both ends of the range
        add_item(32'sh7fff_ffff, 1'b1, 1'b0);
        add_item(32'sh8000_0000, 1'b1, 1'b0);
        // extremes and repeats, scrambled
        add_item(32'sh0000_0000, 1'b0, 1'b0);
        add_item(-32'sd1,        1'b0, 1'b0);
        add_item(32'sh0000_0001, 1'b0, 1'b0);
        add_item(32'sh7fff_ffff, 1'b0, 1'b0);
        add_item(32'sh8000_0000, 1'b0, 1'b0);
        add_item(-32'sd1,        1'b0, 1'b0);
        add_item(32'sh0000_0000, 1'b0, 1'b0);
        add_item(32'sh8000_0000, 1'b0, 1'b0);
        add_item(32'sh7fff_ffff, 1'b0, 1'b0);
        add_item(32'sh0000_0005, 1'b1, 1'b0);
        // strictly descending input: every value moves to the front
        for (int k = 3; k >= -3; k--) add_item(t_data'(k), (k == -3), 1'b0);
        // all equal
        for (int k = 0; k < 3; k++) add_item(32'sh0000_0007, (k == 2), 1'b1);

        // random sets, mostly short; one fills the store exactly and one
        // overruns it so the last value itself is dropped
        set_idx = 0;
        while (item_total < RAND_ITEMS) begin
            if (set_idx == 2)      set_len = SORT_DEPTH;
            else if (set_idx == 6) set_len = SORT_DEPTH + 2;
            else if ($urandom_range(0, 19) == 0) set_len = $urandom_range(20, 40);
            else set_len = $urandom_range(1, 12);
            for (int j = 0; j < set_len; j++)
                add_item(pick_value(), (j == set_len - 1), (j == 0 && set_idx % 5 == 3));
            set_idx++;
        end

        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        run_live = 1'b1;

        while (taken_count < item_total || sorted_due.size() != 0) @(posedge i_clk);
        repeat (SORT_DEPTH + 20) @(posedge i_clk);
        if (err_count == 0) begin
            $display("insertion_sorter_core regression: pass");
        end else begin
            $display("insertion_sorter_core regression: fail");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
src/isort_pkg.sv
src/isort_cell.sv
src/insertion_sorter_core.sv
src/isort_checker.sv
tb/sv/tb_insertion_sorter_core.sv
